@@ rtl/core/mqb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqb_pkg
// Shared widths, register map and step-unit result type for the Morton-run
// quadtree block splitter.
// ----------------------------------------------------------------------------
package mqb_pkg;

   localparam int MAX_LEVELS = 8;
   localparam int CODE_W     = 2 * MAX_LEVELS;   // Morton code of a cell
   localparam int POS_W      = CODE_W + 1;       // also holds the grid size
   localparam int SHIFT_W    = $clog2(CODE_W + 1) + 1;
   localparam int LEVEL_W    = 4;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_LEVELS = CSR_IDX_W'(0);
   localparam logic [LEVEL_W-1:0]   GRID_LEVELS_RESET = LEVEL_W'(MAX_LEVELS);

   // one step of the block walk, decoded from the current position
   typedef struct packed {
      logic               ascend;     // low digit is zero: climb one level
      logic               halt;       // position ran out
      logic               emit;       // current block belongs to the run
      logic               done;       // walk ends after this step
      logic               to_up;      // downward walk passed the run start
      logic [POS_W-1:0]   next_t;
      logic [CODE_W-1:0]  code;
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   up_limit;
   } step_type;

   // clamp the programmed grid depth into the supported range
   function automatic logic [LEVEL_W-1:0] eff_levels(input logic [LEVEL_W-1:0] raw);
      logic [LEVEL_W-1:0] lv;
      lv = raw;
      if (raw < LEVEL_W'(1)) begin
         lv = LEVEL_W'(1);
      end else if (raw > LEVEL_W'(MAX_LEVELS)) begin
         lv = LEVEL_W'(MAX_LEVELS);
      end
      return lv;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/mqb_step_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqb_step_unit
// Shared shift/compare unit: decodes one step of the downward or upward
// quadtree block walk from the position, block size and run bound.
// ----------------------------------------------------------------------------
module mqb_step_unit import mqb_pkg::*; (
   input  wire logic               up_mode,
   input  wire logic [POS_W-1:0]   t,
   input  wire logic [SHIFT_W-1:0] shift,
   input  wire logic [POS_W-1:0]   bound,
   input  wire logic [LEVEL_W-1:0] levels,
   output step_type                res
);

   logic [POS_W-1:0]     t_dec;
   logic [POS_W-1:0]     t_inc;
   logic [POS_W-1:0]     sel;
   logic [POS_W-1:0]     code_w;
   logic [POS_W-1:0]     step;
   logic [LEVEL_W-1:0]   half;
   logic                 below;
   logic                 hit;
   logic                 busy;

   assign t_dec  = t - POS_W'(1);
   assign t_inc  = t + POS_W'(1);
   assign sel    = up_mode ? t : t_dec;
   assign code_w = sel << shift;
   assign step   = POS_W'(1) << shift;
   assign below  = code_w < bound;
   assign hit    = code_w == bound;
   assign half   = shift[LEVEL_W:1];

   always_comb begin
      res.halt     = (t == '0);
      res.ascend   = !res.halt && (t[1:0] == 2'b00);
      busy         = !res.halt && !res.ascend;
      res.code     = code_w[CODE_W-1:0];
      res.up_limit = code_w + step;
      res.level    = (half <= levels) ? (levels - half) : '0;
      if (up_mode) begin
         res.emit   = busy && below;
         res.done   = res.halt || (busy && !below);
         res.to_up  = 1'b0;
         res.next_t = res.ascend ? (t >> 2) : t_inc;
      end else begin
         res.emit   = busy && !below;
         res.done   = res.halt || (busy && !below && hit);
         res.to_up  = busy && below;
         res.next_t = res.ascend ? (t >> 2) : t_dec;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/morton_run_quadtree_blocks_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morton_run_quadtree_blocks_core
// Splits runs of equal cell validity, received in Morton order, into maximal
// aligned quadtree blocks.
// ----------------------------------------------------------------------------
// Each request beat carries one cell. A cell that keeps the current run open
// is taken while the block is idle, and the block stays ready for the next
// cell. A cell that ends a run, or the last cell of the grid, starts a walk
// through one shared shift/compare unit, which emits blocks, climbs quadtree
// levels (at most grid_levels per walk), hands a walk down over to a walk up,
// ends an upward walk, starts the flush walk at the grid end and releases the
// final block. The request side is held off for the whole walk, also while
// the response side stalls. Blocks leave through a one-deep holding stage and
// an output register, and the walk waits while both are full; the last block
// of a cell carries last_of_run. Writing grid_levels (clamped to 1..8)
// restarts the grid at cell 0.
// ----------------------------------------------------------------------------
module morton_run_quadtree_blocks_core import mqb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_cell_valid,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CODE_W-1:0]          rsp_block_code,
   output logic [LEVEL_W-1:0]         rsp_block_level,
   output logic                       rsp_block_valid,
   output logic                       rsp_last_of_run,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOWN,
      ST_UP,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   grid_levels_ff, grid_levels_in;
   logic [CODE_W-1:0]    counter_ff, counter_in;
   logic [CODE_W-1:0]    run_start_ff, run_start_in;
   logic                 run_valid_ff, run_valid_in;
   logic                 flush_ff, flush_in;
   logic [POS_W-1:0]     t_ff, t_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [POS_W-1:0]     bound_ff, bound_in;
   logic                 walk_valid_ff, walk_valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0]    pend_code_ff, pend_code_in;
   logic [LEVEL_W-1:0]   pend_level_ff, pend_level_in;
   logic                 pend_bv_ff, pend_bv_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]    out_code_ff, out_code_in;
   logic [LEVEL_W-1:0]   out_level_ff, out_level_in;
   logic                 out_bv_ff, out_bv_in;
   logic                 out_last_ff, out_last_in;

   logic [LEVEL_W-1:0]   levels;
   logic [POS_W-1:0]     size_w;
   logic [CODE_W-1:0]    size_m1;
   logic [CODE_W-1:0]    cur_cell;
   logic                 cell_last;
   logic                 out_free;
   logic                 can_emit;
   logic                 emit_go;
   logic [CODE_W-1:0]    emit_code;
   logic [LEVEL_W-1:0]   emit_level;
   logic                 emit_bv;
   logic                 csr_hit;
   logic                 csr_wr;
   step_type             step;

   assign levels    = eff_levels(grid_levels_ff);
   assign size_w    = POS_W'(1) << {levels, 1'b0};
   assign size_m1   = CODE_W'(size_w - POS_W'(1));
   assign cur_cell  = (counter_ff > size_m1) ? '0 : counter_ff;
   assign cell_last = (cur_cell == size_m1);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign can_emit  = !pend_valid_ff || out_free;

   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_GRID_LEVELS);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(grid_levels_ff) : '0;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_block_code  = out_code_ff;
   assign rsp_block_level = out_level_ff;
   assign rsp_block_valid = out_bv_ff;
   assign rsp_last_of_run = out_last_ff;

   mqb_step_unit u_step (
      .up_mode (state_ff == ST_UP),
      .t       (t_ff),
      .shift   (shift_ff),
      .bound   (bound_ff),
      .levels  (levels),
      .res     (step)
   );

   always_comb begin
      state_in       = state_ff;
      grid_levels_in = grid_levels_ff;
      counter_in     = counter_ff;
      run_start_in   = run_start_ff;
      run_valid_in   = run_valid_ff;
      flush_in       = flush_ff;
      t_in           = t_ff;
      shift_in       = shift_ff;
      bound_in       = bound_ff;
      walk_valid_in  = walk_valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_code_in   = pend_code_ff;
      pend_level_in  = pend_level_ff;
      pend_bv_in     = pend_bv_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_code_in    = out_code_ff;
      out_level_in   = out_level_ff;
      out_bv_in      = out_bv_ff;
      out_last_in    = out_last_ff;
      emit_go        = 1'b0;
      emit_code      = step.code;
      emit_level     = step.level;
      emit_bv        = walk_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               counter_in = cell_last ? '0 : cur_cell + CODE_W'(1);
               if (cur_cell == '0) begin
                  run_valid_in = req_cell_valid;
                  run_start_in = '0;
               end else if (req_cell_valid != run_valid_ff) begin
                  t_in          = {1'b0, cur_cell};
                  shift_in      = '0;
                  bound_in      = {1'b0, run_start_ff};
                  walk_valid_in = run_valid_ff;
                  run_start_in  = cur_cell;
                  run_valid_in  = req_cell_valid;
                  flush_in      = cell_last;
                  state_in      = ST_DOWN;
               end else if (cell_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_DOWN, ST_UP: begin
            if (step.ascend) begin
               t_in     = step.next_t;
               shift_in = shift_ff + SHIFT_W'(2);
            end else if (step.to_up) begin
               // walked below the run start: fill the rest upward from it
               t_in     = bound_ff;
               bound_in = step.up_limit;
               shift_in = '0;
               state_in = ST_UP;
            end else if (step.emit) begin
               if (can_emit) begin
                  emit_go = 1'b1;
                  t_in    = step.next_t;
                  if (step.done) begin
                     state_in = flush_ff ? ST_FLUSH : ST_FINISH;
                  end
               end
            end else begin
               state_in = flush_ff ? ST_FLUSH : ST_FINISH;
            end
         end
         ST_FLUSH: begin
            if (run_start_ff == '0) begin
               // uniform grid: one root block
               if (can_emit) begin
                  emit_go    = 1'b1;
                  emit_code  = '0;
                  emit_level = '0;
                  emit_bv    = run_valid_ff;
                  flush_in   = 1'b0;
                  state_in   = ST_FINISH;
               end
            end else begin
               t_in          = {1'b0, run_start_ff};
               shift_in      = '0;
               bound_in      = size_w;
               walk_valid_in = run_valid_ff;
               run_start_in  = '0;
               flush_in      = 1'b0;
               state_in      = ST_UP;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_code_in   = pend_code_ff;
               out_level_in  = pend_level_ff;
               out_bv_in     = pend_bv_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the newest block back in the holding stage so the last one can be marked
      if (emit_go) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_code_in  = pend_code_ff;
            out_level_in = pend_level_ff;
            out_bv_in    = pend_bv_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_code_in  = emit_code;
         pend_level_in = emit_level;
         pend_bv_in    = emit_bv;
      end

      if (csr_wr) begin
         grid_levels_in = csr_pwdata[LEVEL_W-1:0];
         counter_in     = '0;
         run_start_in   = '0;
         run_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_levels_ff <= GRID_LEVELS_RESET;
         counter_ff     <= '0;
         run_start_ff   <= '0;
         run_valid_ff   <= 1'b0;
         flush_ff       <= 1'b0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_levels_ff <= grid_levels_in;
         counter_ff     <= counter_in;
         run_start_ff   <= run_start_in;
         run_valid_ff   <= run_valid_in;
         flush_ff       <= flush_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      t_ff          <= t_in;
      shift_ff      <= shift_in;
      bound_ff      <= bound_in;
      walk_valid_ff <= walk_valid_in;
      pend_code_ff  <= pend_code_in;
      pend_level_ff <= pend_level_in;
      pend_bv_ff    <= pend_bv_in;
      out_code_ff   <= out_code_in;
      out_level_ff  <= out_level_in;
      out_bv_ff     <= out_bv_in;
      out_last_ff   <= out_last_in;
   end

endmodule
`default_nettype wire
